// ===== rtl/tild_pkg.sv =====
// Package for the terminal input line discipline.
// Holds buffer sizing, character and destination codes, the shared structs
// and the echo string tables. Depends on nothing.
`default_nettype none
package tild_pkg;

   localparam int BUFFER_BYTES = 56;
   localparam int ADDR_W       = $clog2(BUFFER_BYTES);
   localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
   localparam int THRESHOLD    = BUFFER_BYTES - 2;
   localparam int TAB_STOP     = 10;
   // Division by the tab stop: quotient = (value * RECIP_10) >> RECIP_SHIFT,
   // exact for every value below 64.
   localparam int RECIP_10     = 13;
   localparam int RECIP_SHIFT  = 7;

   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_ECHO_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CR_ECHO     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LF_ECHO     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TAB_ECHO    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BREAK_ALL   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_FULL_DUPLEX = 3'd5;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_ETX   = 8'h03;
   localparam logic [7:0] CH_BEL   = 8'h07;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_DC2   = 8'h12;
   localparam logic [7:0] CH_NAK   = 8'h15;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_U     = 8'h55;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   localparam logic [1:0] DEST_ECHO  = 2'd0;
   localparam logic [1:0] DEST_HOST  = 2'd1;
   localparam logic [1:0] DEST_BREAK = 2'd2;

   // Short fixed-pattern outputs.
   localparam logic [2:0] STR_CRLF   = 3'd0;
   localparam logic [2:0] STR_TAB    = 3'd1;
   localparam logic [2:0] STR_SELF   = 3'd2;
   localparam logic [2:0] STR_BEL    = 3'd3;
   localparam logic [2:0] STR_ERASE  = 3'd4;
   localparam logic [2:0] STR_KILL   = 3'd5;
   localparam logic [2:0] STR_RETYPE = 3'd6;
   localparam logic [2:0] STR_BREAK  = 3'd7;

   // Buffer read-out kinds.
   localparam logic [1:0] SEND_HOST_C = 2'd0;
   localparam logic [1:0] SEND_HOST_I = 2'd1;
   localparam logic [1:0] SEND_ECHO   = 2'd2;

   typedef struct packed {
      logic echo_enable;
      logic cr_echo;
      logic lf_echo;
      logic tab_echo;
      logic break_all;
      logic full_duplex;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic [1:0] dest;
      logic [7:0] ch;
      logic       line_end;
      logic       line_complete;
      logic       last;
   } rsp_type;

   function automatic logic [7:0] str_char(input logic [2:0] sel, input logic [1:0] idx,
                                           input logic [7:0] ch);
      logic [7:0] r;
      r = CH_NUL;
      case (sel)
         STR_CRLF:   r = (idx == 2'd0) ? CH_CR : CH_LF;
         STR_TAB:    r = CH_SP;
         STR_SELF:   r = ch;
         STR_BEL:    r = CH_BEL;
         STR_ERASE:  r = (idx == 2'd1) ? CH_SP : CH_BS;
         STR_KILL: begin
            case (idx)
               2'd0:    r = CH_CARET;
               2'd1:    r = CH_U;
               2'd2:    r = CH_CR;
               default: r = CH_LF;
            endcase
         end
         STR_RETYPE: begin
            case (idx)
               2'd0:    r = CH_CARET;
               2'd1:    r = CH_R;
               2'd2:    r = CH_CR;
               default: r = CH_LF;
            endcase
         end
         default:    r = CH_NUL;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] str_dest(input logic [2:0] sel);
      return (sel == STR_BREAK) ? DEST_BREAK : DEST_ECHO;
   endfunction

   // Spaces up to the next tab stop for a given column.
   function automatic logic [CNT_W-1:0] tab_spaces(input logic [CNT_W-1:0] fill);
      logic [CNT_W+RECIP_SHIFT-1:0] prod;
      logic [CNT_W-1:0]             quot;
      logic [CNT_W+3:0]             tens;
      logic [CNT_W+3:0]             diff;
      prod = (CNT_W + RECIP_SHIFT)'(fill) * (CNT_W + RECIP_SHIFT)'(RECIP_10);
      quot = prod[CNT_W+RECIP_SHIFT-1:RECIP_SHIFT];
      tens = (CNT_W + 4)'(quot) * (CNT_W + 4)'(TAB_STOP);
      diff = (CNT_W + 4)'(fill) - tens;
      return CNT_W'(TAB_STOP) - diff[CNT_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tild_line_ram.sv =====
// Line store: one write port and one registered read port.
// Depends on tild_pkg for depth and the request struct.
`default_nettype none
module tild_line_ram (
   input  wire logic                  clock,
   input  wire tild_pkg::ram_req_type ram_req,
   output logic [7:0]                 rd_data_ff
);
   import tild_pkg::*;

   logic [7:0] line_store [BUFFER_BYTES];

   // Read data holds while no read is issued, so a stalled result keeps it.
   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         line_store[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rd_data_ff <= line_store[ram_req.raddr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tild_csr.sv =====
// Configuration registers of the line discipline, written by index.
// Depends on tild_pkg for register indexes and the config struct.
`default_nettype none
module tild_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [tild_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tild_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output tild_pkg::cfg_type                     cfg_ff
);
   import tild_pkg::*;

   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ECHO_ENABLE: cfg_in.echo_enable = csr_wdata[0];
            REG_CR_ECHO:     cfg_in.cr_echo     = csr_wdata[0];
            REG_LF_ECHO:     cfg_in.lf_echo     = csr_wdata[0];
            REG_TAB_ECHO:    cfg_in.tab_echo    = csr_wdata[0];
            REG_BREAK_ALL:   cfg_in.break_all   = csr_wdata[0];
            REG_FULL_DUPLEX: cfg_in.full_duplex = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{echo_enable: 1'b0, cr_echo: 1'b0, lf_echo: 1'b0, tab_echo: 1'b0,
                     break_all: 1'b0, full_duplex: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tild_seq.sv =====
// Character decode and result sequencer: plans the echo and line actions
// for one item, reads the line store back and drives the result register.
// Depends on tild_pkg; drives the port of tild_line_ram.
`default_nettype none
module tild_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tild_pkg::cfg_type     cfg,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_char,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output tild_pkg::rsp_type          rsp,
   output tild_pkg::ram_req_type      ram_req,
   input  wire logic [7:0]            rd_data
);
   import tild_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ECHO = 2'd1;
   localparam logic [1:0] S_ACT  = 2'd2;
   localparam logic [1:0] S_SEND = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [7:0]       ch_ff, ch_in;
   logic [2:0]       e_sel_ff, e_sel_in, a_sel_ff, a_sel_in;
   logic [CNT_W-1:0] e_len_ff, e_len_in, a_len_ff, a_len_in, s_len_ff, s_len_in;
   logic [1:0]       s_mode_ff, s_mode_in;
   logic             store_after_ff, store_after_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rd_pend_ff, rd_pend_in;
   rsp_type          out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   // Decode of the offered character.
   logic [7:0]       ch_tr;
   logic [2:0]       d_e_sel, d_a_sel;
   logic [CNT_W-1:0] d_e_len, d_a_len, d_s_len, d_fill;
   logic [1:0]       d_s_mode;
   logic             d_store_after, d_we;
   logic [7:0]       d_wdata;
   logic             quiet_char, can_store;

   // Result generation.
   logic             emit_valid, fire, phase_last;
   rsp_type          emit;
   logic [CNT_W-1:0] cur_len;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   always_comb begin
      ch_tr         = (req_char == CH_CR) ? CH_LF : req_char;
      quiet_char    = (req_char == CH_DC2) || (req_char == CH_NAK) || (req_char == CH_BS) ||
                      (req_char == CH_DEL) || (req_char == CH_LF) || (req_char == CH_CR) ||
                      (req_char == CH_FF) || (req_char == CH_ETX);
      can_store     = (fill_ff < CNT_W'(BUFFER_BYTES));
      d_e_sel       = STR_SELF;
      d_e_len       = '0;
      d_a_sel       = STR_SELF;
      d_a_len       = '0;
      d_s_len       = '0;
      d_s_mode      = SEND_HOST_C;
      d_store_after = 1'b0;
      d_we          = 1'b0;
      d_wdata       = ch_tr;
      d_fill        = fill_ff;

      if (cfg.echo_enable) begin
         if (cfg.cr_echo && req_char == CH_LF) begin
            d_e_sel = STR_CRLF;
            d_e_len = CNT_W'(2);
         end else if (cfg.lf_echo && req_char == CH_CR) begin
            d_e_sel = STR_CRLF;
            d_e_len = CNT_W'(2);
         end else if (cfg.tab_echo && req_char == CH_TAB) begin
            d_e_sel = STR_TAB;
            d_e_len = tab_spaces(fill_ff);
         end else if (!quiet_char) begin
            d_e_sel = STR_SELF;
            d_e_len = CNT_W'(1);
         end
      end

      if (cfg.break_all) begin
         // The raw byte joins the buffer and the whole buffer goes out.
         d_we     = can_store;
         d_wdata  = req_char;
         d_s_mode = SEND_HOST_C;
         d_s_len  = can_store ? fill_ff + CNT_W'(1) : fill_ff;
         d_fill   = '0;
      end else if (fill_ff >= CNT_W'(THRESHOLD)) begin
         // Flush as incomplete; the byte is written to the front afterwards.
         d_s_mode      = SEND_HOST_I;
         d_s_len       = fill_ff;
         d_store_after = 1'b1;
         d_fill        = CNT_W'(1);
      end else if (ch_tr == CH_LF || ch_tr == CH_FF) begin
         d_we     = can_store;
         d_wdata  = CH_LF;
         d_s_mode = SEND_HOST_C;
         d_s_len  = can_store ? fill_ff + CNT_W'(1) : fill_ff;
         d_fill   = '0;
      end else if (ch_tr == CH_ETX) begin
         d_a_sel = STR_BREAK;
         d_a_len = CNT_W'(1);
      end else if (ch_tr == CH_BS || ch_tr == CH_DEL) begin
         if (fill_ff != '0) begin
            d_a_sel = STR_ERASE;
            d_a_len = CNT_W'(3);
            d_fill  = fill_ff - CNT_W'(1);
         end else begin
            d_a_sel = STR_BEL;
            d_a_len = CNT_W'(1);
         end
      end else if (ch_tr == CH_NAK) begin
         d_a_sel = STR_KILL;
         d_a_len = CNT_W'(4);
         d_fill  = '0;
      end else if (ch_tr == CH_DC2) begin
         d_a_sel  = STR_RETYPE;
         d_a_len  = CNT_W'(4);
         d_s_mode = SEND_ECHO;
         d_s_len  = fill_ff;
      end else begin
         if (!cfg.full_duplex) begin
            d_a_sel = STR_SELF;
            d_a_len = CNT_W'(1);
         end
         d_we = can_store;
         if (can_store) begin
            d_fill = fill_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      emit       = '0;
      emit_valid = 1'b0;
      cur_len    = s_len_ff;
      case (state_ff)
         S_ECHO:  cur_len = e_len_ff;
         S_ACT:   cur_len = a_len_ff;
         default: cur_len = s_len_ff;
      endcase
      phase_last = (idx_ff == cur_len - CNT_W'(1));
      case (state_ff)
         S_ECHO: begin
            emit_valid = 1'b1;
            emit.dest  = str_dest(e_sel_ff);
            emit.ch    = str_char(e_sel_ff, idx_ff[1:0], ch_ff);
            emit.last  = phase_last && (a_len_ff == '0) && (s_len_ff == '0);
         end
         S_ACT: begin
            emit_valid = 1'b1;
            emit.dest  = str_dest(a_sel_ff);
            emit.ch    = str_char(a_sel_ff, idx_ff[1:0], ch_ff);
            emit.last  = phase_last && (s_len_ff == '0);
         end
         S_SEND: begin
            emit_valid         = rd_pend_ff;
            emit.dest          = (s_mode_ff == SEND_ECHO) ? DEST_ECHO : DEST_HOST;
            emit.ch            = rd_data;
            emit.line_end      = (s_mode_ff != SEND_ECHO) && phase_last;
            emit.line_complete = (s_mode_ff == SEND_HOST_C);
            emit.last          = phase_last;
         end
         default: emit_valid = 1'b0;
      endcase
      fire = emit_valid && (!out_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in       = state_ff;
      ch_in          = ch_ff;
      e_sel_in       = e_sel_ff;
      e_len_in       = e_len_ff;
      a_sel_in       = a_sel_ff;
      a_len_in       = a_len_ff;
      s_mode_in      = s_mode_ff;
      s_len_in       = s_len_ff;
      store_after_in = store_after_ff;
      fill_in        = fill_ff;
      idx_in         = idx_ff;
      rd_pend_in     = rd_pend_ff;
      ram_req        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ch_in          = ch_tr;
               e_sel_in       = d_e_sel;
               e_len_in       = d_e_len;
               a_sel_in       = d_a_sel;
               a_len_in       = d_a_len;
               s_mode_in      = d_s_mode;
               s_len_in       = d_s_len;
               store_after_in = d_store_after;
               fill_in        = d_fill;
               idx_in         = '0;
               rd_pend_in     = 1'b0;
               ram_req.we     = d_we;
               ram_req.waddr  = ADDR_W'(fill_ff);
               ram_req.wdata  = d_wdata;
               if (d_e_len != '0) begin
                  state_in = S_ECHO;
               end else if (d_a_len != '0) begin
                  state_in = S_ACT;
               end else if (d_s_len != '0) begin
                  state_in = S_SEND;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ECHO: begin
            if (fire) begin
               if (phase_last) begin
                  idx_in = '0;
                  if (a_len_ff != '0) begin
                     state_in = S_ACT;
                  end else if (s_len_ff != '0) begin
                     state_in = S_SEND;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
         S_ACT: begin
            if (fire) begin
               if (phase_last) begin
                  idx_in   = '0;
                  state_in = (s_len_ff != '0) ? S_SEND : S_IDLE;
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
         S_SEND: begin
            // Writes to the store happen only in the accept cycle or after the
            // last read, so a read never meets a write to the same entry.
            if (!rd_pend_ff) begin
               ram_req.re    = 1'b1;
               ram_req.raddr = ADDR_W'(idx_ff);
               rd_pend_in    = 1'b1;
            end else if (fire) begin
               if (phase_last) begin
                  state_in      = S_IDLE;
                  idx_in        = '0;
                  rd_pend_in    = 1'b0;
                  ram_req.we    = store_after_ff;
                  ram_req.waddr = '0;
                  ram_req.wdata = ch_ff;
               end else begin
                  idx_in        = idx_ff + CNT_W'(1);
                  ram_req.re    = 1'b1;
                  ram_req.raddr = ADDR_W'(idx_ff + CNT_W'(1));
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_in       = emit;
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff          <= ch_in;
      e_sel_ff       <= e_sel_in;
      e_len_ff       <= e_len_in;
      a_sel_ff       <= a_sel_in;
      a_len_ff       <= a_len_in;
      s_mode_ff      <= s_mode_in;
      s_len_ff       <= s_len_in;
      store_after_ff <= store_after_in;
      out_ff         <= out_in;
   end

endmodule
`default_nettype wire

// ===== rtl/terminal_input_line_discipline.sv =====
// The first result of an item is registered after accept, once the sequencer has left idle and,
// for a buffer read-out, the first store read has returned. Throughput: one result per cycle
// while the receiver keeps taking them. The next item is taken once the last result
// of the previous one is registered.
// Reset (synchronous, active high) empties the fill count, restores the configuration
// defaults and idles the sequencer; the line store is not cleared.
`default_nettype none
module terminal_input_line_discipline (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,  // [7:0] in_char
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [15:0]                           rsp_tdata,  // [7:0] out_char, [8] last_result
   output logic [2:0]                            rsp_tuser,  // [1:0] dest, [2] line_complete
   output logic                                  rsp_tlast,  // line_end
   input  wire logic                             csr_we,
   input  wire logic [tild_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tild_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tild_pkg::*;

   cfg_type     cfg;
   ram_req_type ram_req;
   rsp_type     rsp;
   logic [7:0]  rd_data;

   tild_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_ff    (cfg)
   );

   tild_line_ram u_ram (
      .clock      (clock),
      .ram_req    (ram_req),
      .rd_data_ff (rd_data)
   );

   tild_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_char  (req_tdata),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp),
      .ram_req   (ram_req),
      .rd_data   (rd_data)
   );

   assign rsp_tdata = {7'b0, rsp.last, rsp.ch};
   assign rsp_tuser = {rsp.line_complete, rsp.dest};
   assign rsp_tlast = rsp.line_end;

endmodule
`default_nettype wire

// ===== rtl/tild_checker.sv =====
// Port-level checks of the line discipline result stream, bound to the top level.
// Depends on tild_pkg for destination codes.
`default_nettype none
module tild_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import tild_pkg::*;

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // The end of a host line is always the final result of its item.
   a_line_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tuser[1:0] == DEST_HOST) && rsp_tdata[8])
      else $error("line end not on the final host result");

   // Echo and break results carry no line flags.
   a_echo_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] != DEST_HOST) |-> !rsp_tuser[2] && !rsp_tlast)
      else $error("line flags on a non-host result");

   // A line break is a lone zero byte ending its item.
   a_break_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == DEST_BREAK) |-> (rsp_tdata[7:0] == CH_NUL) && rsp_tdata[8])
      else $error("malformed line break result");

endmodule

bind terminal_input_line_discipline tild_checker u_checker (.*);
`default_nettype wire

// ===== verif/tb_terminal_input_line_discipline.sv =====
// Self-checking testbench for terminal_input_line_discipline.
// Drives typed characters and register writes, predicts every echo, host and break
// output in its own model of the line discipline. Needs tild_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_terminal_input_line_discipline;
   import tild_pkg::*;

   localparam int MAX_RESULTS = 64;
   localparam int SETTLE_CYCLES = 16;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [7:0] in_char
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [15:0]            rsp_tdata;   // [7:0] out_char, [8] last_result
   logic [2:0]             rsp_tuser;   // [1:0] dest, [2] line_complete
   logic                   rsp_tlast;   // line_end
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   terminal_input_line_discipline u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Model of the line discipline: buffer, fill count and register copy.
   logic [7:0] line_copy [BUFFER_BYTES];
   int         fill_copy;
   cfg_type    cfg_copy;
   rsp_type    char_outputs [$];
   rsp_type    line_output_q [$];

   int   errors;
   bit   idle_on;
   bit   hold_request;
   int   hold_len;

   function automatic cfg_type make_cfg(input logic echo, input logic cr, input logic lf,
                                        input logic tab, input logic brk, input logic fdx);
      cfg_type c;
      c.echo_enable = echo;
      c.cr_echo     = cr;
      c.lf_echo     = lf;
      c.tab_echo    = tab;
      c.break_all   = brk;
      c.full_duplex = fdx;
      return c;
   endfunction

   function automatic void add_output(input logic [1:0] dest, input logic [7:0] ch,
                                      input logic lend, input logic lcomp);
      rsp_type r;
      if (char_outputs.size() >= MAX_RESULTS) return;
      r.dest          = dest;
      r.ch            = ch;
      r.line_end      = lend;
      r.line_complete = lcomp;
      r.last          = 1'b0;
      char_outputs.push_back(r);
   endfunction

   function automatic void echo_byte(input logic [7:0] ch);
      add_output(DEST_ECHO, ch, 1'b0, 1'b0);
   endfunction

   function automatic void store_copy(input logic [7:0] ch);
      if (fill_copy < BUFFER_BYTES) begin
         line_copy[fill_copy] = ch;
         fill_copy++;
      end
   endfunction

   function automatic void flush_line(input logic complete);
      for (int i = 0; i < fill_copy; i++)
         add_output(DEST_HOST, line_copy[i], (i + 1 == fill_copy), complete);
      fill_copy = 0;
   endfunction

   // Works out every output one typed character causes and queues them.
   function automatic void predict_line_discipline(input logic [7:0] typed);
      logic [7:0] ch;
      int         spaces;
      ch = typed;
      char_outputs.delete();
      if (cfg_copy.echo_enable) begin
         if ((cfg_copy.cr_echo && ch == CH_LF) || (cfg_copy.lf_echo && ch == CH_CR)) begin
            echo_byte(CH_CR);
            echo_byte(CH_LF);
         end else if (cfg_copy.tab_echo && ch == CH_TAB) begin
            spaces = TAB_STOP - (fill_copy % TAB_STOP);
            for (int i = 0; i < spaces; i++) echo_byte(CH_SP);
         end else if (!(ch inside {CH_DC2, CH_NAK, CH_BS, CH_DEL, CH_LF, CH_CR, CH_FF,
                                   CH_ETX})) begin
            echo_byte(ch);
         end
      end
      if (cfg_copy.break_all) begin
         store_copy(ch);
         flush_line(1'b1);
      end else begin
         if (ch == CH_CR) ch = CH_LF;
         // A nearly full buffer goes out as incomplete and the byte starts a new line,
         // whatever kind of byte it is.
         if (fill_copy >= THRESHOLD) begin
            flush_line(1'b0);
            store_copy(ch);
         end else if (ch == CH_LF || ch == CH_FF) begin
            store_copy(CH_LF);
            flush_line(1'b1);
         end else if (ch == CH_ETX) begin
            add_output(DEST_BREAK, CH_NUL, 1'b0, 1'b0);
         end else if (ch == CH_BS || ch == CH_DEL) begin
            if (fill_copy > 0) begin
               echo_byte(CH_BS);
               echo_byte(CH_SP);
               echo_byte(CH_BS);
               fill_copy--;
            end else begin
               echo_byte(CH_BEL);
            end
         end else if (ch == CH_NAK) begin
            fill_copy = 0;
            echo_byte(CH_CARET);
            echo_byte(CH_U);
            echo_byte(CH_CR);
            echo_byte(CH_LF);
         end else if (ch == CH_DC2) begin
            echo_byte(CH_CARET);
            echo_byte(CH_R);
            echo_byte(CH_CR);
            echo_byte(CH_LF);
            for (int i = 0; i < fill_copy; i++) echo_byte(line_copy[i]);
         end else begin
            if (!cfg_copy.full_duplex) echo_byte(ch);
            store_copy(ch);
         end
      end
      if (char_outputs.size() > 0) char_outputs[char_outputs.size() - 1].last = 1'b1;
      foreach (char_outputs[i]) line_output_q.push_back(char_outputs[i]);
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Entered at a falling edge; returns at the falling edge after the item is taken,
   // with valid still high so that a following item can go out back to back.
   task automatic send_char(input logic [7:0] ch);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
      predict_line_discipline(ch);
      @(negedge clock);
   endtask

   // Stops offering items and waits until every expected output has come out,
   // plus a settling wait of SETTLE_CYCLES for an item that produces nothing.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (line_output_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      wait_drained();
      write_reg(REG_ECHO_ENABLE, c.echo_enable);
      write_reg(REG_CR_ECHO, c.cr_echo);
      write_reg(REG_LF_ECHO, c.lf_echo);
      write_reg(REG_TAB_ECHO, c.tab_echo);
      write_reg(REG_BREAK_ALL, c.break_all);
      write_reg(REG_FULL_DUPLEX, c.full_duplex);
      csr_we   <= 1'b0;
      cfg_copy = c;
   endtask

   function automatic logic [7:0] printable_char();
      return 8'($urandom_range(CH_SP, CH_DEL - 1));
   endfunction

   function automatic logic [7:0] typed_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return printable_char();
      if (r < 79) return CH_BS;
      if (r < 83) return CH_DEL;
      if (r < 87) return CH_TAB;
      if (r < 90) return CH_DC2;
      if (r < 92) return CH_NAK;
      if (r < 94) return CH_ETX;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] line_ender();
      case ($urandom_range(0, 2))
         0:       return CH_CR;
         1:       return CH_LF;
         default: return CH_FF;
      endcase
   endfunction

   // Mostly well-formed typed lines, some lines long enough to hit the flush point,
   // and single raw bytes as noise.
   task automatic send_random_text(input int n_items);
      int sent;
      int pick;
      int len;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            len = $urandom_range(0, 14);
            for (int k = 0; k < len; k++) send_char(typed_char());
            send_char(line_ender());
            sent += len + 1;
         end else if (pick < 72) begin
            len = $urandom_range(THRESHOLD - 2, BUFFER_BYTES + 4);
            for (int k = 0; k < len; k++)
               send_char(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                     : printable_char());
            sent += len;
         end else begin
            send_char(8'($urandom_range(0, 255)));
            sent++;
         end
      end
   endtask

   task automatic test_reset_defaults();
      send_char("A");
      send_char(8'h00);
      send_char(8'hFF);
      send_char(CH_CR);
      send_char(CH_BS);
      send_char(CH_ETX);
      wait_drained();
   endtask

   task automatic test_edit_keys();
      apply_config(make_cfg(1, 1, 1, 1, 0, 1));
      send_char("h");
      send_char("i");
      send_char(CH_TAB);
      send_char(CH_BS);
      send_char(CH_DEL);
      send_char(CH_DC2);
      send_char(CH_NAK);
      send_char(CH_DEL);
      send_char("x");
      send_char(CH_LF);
      send_char(CH_FF);
      send_char(CH_CR);
      apply_config(make_cfg(0, 0, 0, 0, 0, 0));
      send_char("q");
      send_char(8'h80);
      send_char(CH_TAB);
      send_char(CH_LF);
      wait_drained();
   endtask

   // Lines that reach the flush point, with a plain byte, a control and a CR
   // arriving once the buffer holds THRESHOLD bytes.
   task automatic test_overflow_flush();
      logic [7:0] at_full [3];
      apply_config(make_cfg(1, 0, 0, 1, 0, 1));
      at_full[0] = printable_char();
      at_full[1] = CH_NAK;
      at_full[2] = CH_CR;
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < THRESHOLD; k++) send_char(printable_char());
         send_char(at_full[j]);
         send_char(line_ender());
      end
      wait_drained();
   endtask

   task automatic test_break_all();
      apply_config(make_cfg(0, 0, 0, 0, 0, 1));
      for (int k = 0; k < 5; k++) send_char(printable_char());
      apply_config(make_cfg(1, 1, 1, 1, 1, 0));
      send_char(CH_TAB);
      for (int k = 0; k < 30; k++) send_char(8'($urandom_range(0, 255)));
      wait_drained();
   endtask

   task automatic test_random_settings();
      cfg_type settings [6];
      settings[0] = make_cfg(0, 0, 0, 0, 0, 0);
      settings[1] = make_cfg(1, 1, 1, 1, 1, 1);
      settings[2] = make_cfg(1, 1, 1, 1, 0, 1);
      settings[3] = make_cfg(1, 0, 0, 0, 0, 0);
      settings[4] = make_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0,
                             1'($urandom_range(0, 1)));
      settings[5] = make_cfg(1, 0, 1, 1, 0, 1);
      foreach (settings[s]) begin
         apply_config(settings[s]);
         // Every other setting runs without any idling on either side.
         idle_on = (s % 2 == 0);
         send_random_text(20);
      end
      idle_on = 1'b1;
      wait_drained();
   endtask

   // The receiver stops for a long stretch while the sender keeps offering items.
   task automatic test_backpressure();
      apply_config(make_cfg(1, 1, 1, 1, 0, 0));
      idle_on      = 1'b0;
      hold_len     = 400;
      hold_request = 1'b1;
      send_random_text(40);
      idle_on = 1'b1;
      wait_drained();
   endtask

   // Receiver: random stalls, an occasional long one, and a counted hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            for (int k = 0; k < hold_len; k++) @(negedge clock);
            hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!idle_on) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 199) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(20, 80)) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) < 70);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.dest          = rsp_tuser[1:0];
         seen.ch            = rsp_tdata[7:0];
         seen.line_end      = rsp_tlast;
         seen.line_complete = rsp_tuser[2];
         seen.last          = rsp_tdata[8];
         if (line_output_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected item dest=%0d char=%02h end=%0b complete=%0b last=%0b",
                     $realtime, seen.dest, seen.ch, seen.line_end, seen.line_complete,
                     seen.last);
         end else begin
            want = line_output_q.pop_front();
            if (seen !== want) begin
               errors++;
               $display({"%0t: mismatch expected dest=%0d char=%02h end=%0b complete=%0b",
                         " last=%0b, actual dest=%0d char=%02h end=%0b complete=%0b last=%0b"},
                        $realtime, want.dest, want.ch, want.line_end, want.line_complete,
                        want.last, seen.dest, seen.ch, seen.line_end, seen.line_complete,
                        seen.last);
            end
         end
      end
   end

   initial begin
      #40_000_000;
      $display("terminal_input_line_discipline verification failed");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      errors       = 0;
      idle_on      = 1'b1;
      hold_request = 1'b0;
      hold_len     = 0;
      fill_copy    = 0;
      cfg_copy     = make_cfg(0, 0, 0, 0, 0, 1);
      foreach (line_copy[i]) line_copy[i] = 8'h00;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_edit_keys();
      test_overflow_flush();
      test_break_all();
      test_random_settings();
      test_backpressure();

      wait_drained();
      if (errors == 0 && line_output_q.size() == 0) begin
         $display("terminal_input_line_discipline verification clean");
      end else begin
         $display("terminal_input_line_discipline verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tild_pkg.sv
rtl/tild_line_ram.sv
rtl/tild_csr.sv
rtl/tild_seq.sv
rtl/terminal_input_line_discipline.sv
rtl/tild_checker.sv
verif/tb_terminal_input_line_discipline.sv
